// ===== design/lgs_pkg.sv =====
// Shared constants for the toroidal life generation block.
`timescale 1ns / 1ps

package lgs_pkg;

    localparam int DEF_ROWS = 25;
    localparam int DEF_COLS = 80;

    localparam int FUNC_W = 2;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam int NBR_W = 4;
    localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

endpackage

// ===== design/lgs_row_mem.sv =====
// Row store of the grid: one write port, one registered read port, row valid bits.
`timescale 1ns / 1ps

module lgs_row_mem
    import lgs_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS,
    parameter int RW   = $clog2(ROWS)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  logic [RW-1:0]   rd_addr,
    output logic [COLS-1:0] rd_data,
    input  logic            wr_en,
    input  logic [RW-1:0]   wr_addr,
    input  logic [COLS-1:0] wr_data
);

    logic [COLS-1:0] row_mem_reg [ROWS];
    logic [ROWS-1:0] valid_reg;
    logic [COLS-1:0] rdata_reg;
    logic            rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= row_mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written rows read as dead
    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

// ===== design/lgs_row_rule.sv =====
// B3/S23 rule across one row, neighbours wrapping at the row ends.
`timescale 1ns / 1ps

module lgs_row_rule
    import lgs_pkg::*;
#(
    parameter int COLS = DEF_COLS
)
(
    input  logic [COLS-1:0] above,
    input  logic [COLS-1:0] cur,
    input  logic [COLS-1:0] below,
    output logic [COLS-1:0] next_row
);

    for (genvar c = 0; c < COLS; c++)
    begin : g_col
        localparam int L = (c == 0) ? COLS - 1 : c - 1;
        localparam int R = (c == COLS - 1) ? 0 : c + 1;
        logic [NBR_W-1:0] n;

        assign n = {3'b000, above[L]} + {3'b000, above[c]} + {3'b000, above[R]}
                 + {3'b000, cur[L]}   + {3'b000, cur[R]}
                 + {3'b000, below[L]} + {3'b000, below[c]} + {3'b000, below[R]};
        assign next_row[c] = (n == BIRTH_COUNT) || (cur[c] && (n == SURVIVE_COUNT));
    end

endmodule

// ===== design/life_toroidal_generation_step.sv =====
// Toroidal life grid: sequencer, row buffers and result register.
//
// Request channel (req_valid / req_stall) carries one item per operation:
// func selects write cell, advance one generation or read cell; row, col
// and value address and supply the cell. Every item gives exactly one result
// item on the response channel (rsp_valid / rsp_stall): cell_alive holds the
// cell for a read and 0 otherwise, done_res is always 1.
// Steps: a write or read reads its row from the row store, then modifies
// or selects, then loads the response register; an out-of-range address
// or unused code goes straight to loading the response. A generation step
// first loads the wrap row and row 0, then the shared row rule unit
// produces one new row per cycle as the row store streams the next row
// out of its read port. req_stall is high while an item is at work.
// The response register lets a new item in while a result waits; an item
// that finishes while the previous result is still stalled holds there.
// Reset clears the grid (row valid bits) and empties the response register.
`timescale 1ns / 1ps

module life_toroidal_generation_step
    import lgs_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [FUNC_W-1:0] func,
    input  logic [ROW_W-1:0]  row,
    input  logic [COL_W-1:0]  col,
    input  logic              value,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic              cell_alive,
    output logic              done_res
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRE1  = 3'd1;
    localparam logic [2:0] S_PRE2  = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_WR    = 3'd4;
    localparam logic [2:0] S_RD    = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]      state_reg, state_next;
    logic [RW-1:0]   cnt_reg, cnt_next;
    logic [RW-1:0]   addr_reg, addr_next;
    logic [CW-1:0]   cidx_reg, cidx_next;
    logic            val_reg, val_next;
    logic            res_reg, res_next;
    logic [COLS-1:0] above_reg, above_next;
    logic [COLS-1:0] cur_reg, cur_next;
    logic [COLS-1:0] first_reg, first_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic            alive_reg, alive_next;

    logic            rd_en, wr_en;
    logic [RW-1:0]   rd_addr, wr_addr;
    logic [COLS-1:0] rd_data, wr_data;
    logic [COLS-1:0] below, rule_row, mod_row;
    logic            accept, in_range;

    lgs_row_mem #(.ROWS(ROWS), .COLS(COLS), .RW(RW)) u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    lgs_row_rule #(.COLS(COLS)) u_rule
    (
        .above    (above_reg),
        .cur      (cur_reg),
        .below    (below),
        .next_row (rule_row)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign in_range  = (32'(row) < ROWS) && (32'(col) < COLS);
    assign below     = (cnt_reg == LAST_ROW) ? first_reg : rd_data;

    always_comb
    begin
        mod_row           = rd_data;
        mod_row[cidx_reg] = val_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        cidx_next      = cidx_reg;
        val_next       = val_reg;
        res_next       = res_reg;
        above_next     = above_reg;
        cur_next       = cur_reg;
        first_next     = first_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        alive_next     = alive_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg;
        wr_data        = rule_row;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    addr_next  = RW'(row);
                    cidx_next  = CW'(col);
                    val_next   = value;
                    res_next   = 1'b0;
                    state_next = S_FIN;
                    case (func)
                        FUNC_WRITE:
                        begin
                            if (in_range)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = RW'(row);
                                state_next = S_WR;
                            end
                        end
                        FUNC_STEP:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = LAST_ROW;
                            state_next = S_PRE1;
                        end
                        FUNC_READ:
                        begin
                            if (in_range)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = RW'(row);
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_PRE1:
            begin
                above_next = rd_data;
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_PRE2;
            end
            S_PRE2:
            begin
                cur_next   = rd_data;
                first_next = rd_data;
                rd_en      = 1'b1;
                rd_addr    = RW'(1);
                cnt_next   = '0;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                wr_en      = 1'b1;
                above_next = cur_reg;
                cur_next   = below;
                if (32'(cnt_reg) + 2 < ROWS)
                begin
                    rd_en   = 1'b1;
                    rd_addr = RW'(32'(cnt_reg) + 2);
                end
                if (cnt_reg == LAST_ROW)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + RW'(1);
                end
            end
            S_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = addr_reg;
                wr_data    = mod_row;
                state_next = S_FIN;
            end
            S_RD:
            begin
                res_next   = rd_data[cidx_reg];
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    alive_next     = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        cidx_reg  <= cidx_next;
        val_reg   <= val_next;
        res_reg   <= res_next;
        above_reg <= above_next;
        cur_reg   <= cur_next;
        first_reg <= first_next;
        alive_reg <= alive_next;
    end

    assign rsp_valid  = rsp_valid_reg;
    assign cell_alive = alive_reg;
    assign done_res   = 1'b1;

endmodule

// ===== dv/tb_life_toroidal_generation_step.sv =====
`timescale 1ns / 1ps
// Testbench for the toroidal life grid block: directed table, then random operations, all checked.

module tb_life_toroidal_generation_step;
    import lgs_pkg::*;

    localparam int ROWS       = DEF_ROWS;
    localparam int COLS       = DEF_COLS;
    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM   = 480;
    localparam int N_CALM     = 60;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 40;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic [ROW_W-1:0]  r;
        logic [COL_W-1:0]  c;
        logic              v;
        logic              typed;
        logic              alive;
    } grid_op_t;

    typedef struct packed {
        logic alive;
        logic done;
    } cell_result_t;

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              req_valid      = 1'b0;
    logic              req_stall;
    logic [FUNC_W-1:0] func           = FUNC_WRITE;
    logic [ROW_W-1:0]  row            = '0;
    logic [COL_W-1:0]  col            = '0;
    logic              value          = 1'b0;
    logic              rsp_valid;
    logic              rsp_stall      = 1'b0;
    logic              cell_alive;
    logic              done_res;

    logic              op_typed       = 1'b0;
    logic              op_typed_alive = 1'b0;
    logic              calm           = 1'b0;
    int                stall_left     = 0;
    int                idle_cycles    = 0;
    int                fail_count     = 0;

    logic [COLS-1:0]   life_grid [ROWS];
    cell_result_t      pending_cells [$];

    // expected cell typed only where obvious; blinker straddles the column wrap
    grid_op_t directed_ops [N_DIRECTED] = '{
        '{FUNC_READ,  5'd0,  7'd0,   1'b0, 1'b1, 1'b0},
        '{FUNC_READ,  5'd24, 7'd79,  1'b0, 1'b1, 1'b0},
        '{FUNC_WRITE, 5'd0,  7'd0,   1'b1, 1'b0, 1'b0},
        '{FUNC_READ,  5'd0,  7'd0,   1'b0, 1'b1, 1'b1},
        '{FUNC_WRITE, 5'd24, 7'd79,  1'b1, 1'b0, 1'b0},
        '{FUNC_READ,  5'd24, 7'd79,  1'b0, 1'b1, 1'b1},
        '{FUNC_WRITE, 5'd25, 7'd0,   1'b1, 1'b0, 1'b0},
        '{FUNC_WRITE, 5'd0,  7'd80,  1'b1, 1'b0, 1'b0},
        '{FUNC_WRITE, 5'd31, 7'd127, 1'b1, 1'b0, 1'b0},
        '{FUNC_READ,  5'd25, 7'd0,   1'b1, 1'b1, 1'b0},
        '{FUNC_READ,  5'd31, 7'd127, 1'b0, 1'b1, 1'b0},
        '{FUNC_SPARE, 5'd0,  7'd0,   1'b1, 1'b1, 1'b0},
        '{FUNC_WRITE, 5'd24, 7'd79,  1'b0, 1'b0, 1'b0},
        '{FUNC_READ,  5'd24, 7'd79,  1'b0, 1'b1, 1'b0},
        '{FUNC_WRITE, 5'd0,  7'd79,  1'b1, 1'b0, 1'b0},
        '{FUNC_WRITE, 5'd0,  7'd1,   1'b1, 1'b0, 1'b0},
        '{FUNC_STEP,  5'd31, 7'd127, 1'b1, 1'b0, 1'b0},
        '{FUNC_READ,  5'd24, 7'd0,   1'b0, 1'b0, 1'b0},
        '{FUNC_READ,  5'd0,  7'd0,   1'b0, 1'b0, 1'b0},
        '{FUNC_READ,  5'd1,  7'd0,   1'b0, 1'b0, 1'b0},
        '{FUNC_READ,  5'd0,  7'd79,  1'b0, 1'b0, 1'b0},
        '{FUNC_STEP,  5'd0,  7'd0,   1'b0, 1'b0, 1'b0},
        '{FUNC_READ,  5'd0,  7'd79,  1'b0, 1'b0, 1'b0},
        '{FUNC_READ,  5'd24, 7'd0,   1'b0, 1'b0, 1'b0},
        '{FUNC_READ,  5'd0,  7'd1,   1'b1, 1'b0, 1'b0}
    };

    life_toroidal_generation_step DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .func       (func),
        .row        (row),
        .col        (col),
        .value      (value),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .cell_alive (cell_alive),
        .done_res   (done_res)
    );

    always #4 clk = ~clk;

    initial
    begin
        for (int i = 0; i < ROWS; i++)
            life_grid[i] = '0;
    end

    // one B3/S23 generation over the whole torus, all cells from the old grid
    function automatic void evolve_grid();
        logic [COLS-1:0] nxt [ROWS];
        int up, dn, lf, rt, n;
        for (int i = 0; i < ROWS; i++)
        begin
            up = (i + ROWS - 1) % ROWS;
            dn = (i + 1) % ROWS;
            for (int j = 0; j < COLS; j++)
            begin
                lf = (j + COLS - 1) % COLS;
                rt = (j + 1) % COLS;
                n = int'(life_grid[up][lf]) + int'(life_grid[up][j]) + int'(life_grid[up][rt])
                  + int'(life_grid[i][lf]) + int'(life_grid[i][rt])
                  + int'(life_grid[dn][lf]) + int'(life_grid[dn][j]) + int'(life_grid[dn][rt]);
                nxt[i][j] = (n == int'(BIRTH_COUNT))
                         || (life_grid[i][j] && n == int'(SURVIVE_COUNT));
            end
        end
        for (int i = 0; i < ROWS; i++)
            life_grid[i] = nxt[i];
    endfunction

    function automatic cell_result_t predict_cell_result(input logic [FUNC_W-1:0] op,
                                                         input logic [ROW_W-1:0]  r,
                                                         input logic [COL_W-1:0]  c,
                                                         input logic              v);
        cell_result_t res;
        logic         in_grid;
        res.alive = 1'b0;
        res.done  = 1'b1;
        in_grid   = (int'(r) < ROWS) && (int'(c) < COLS);
        case (op)
            FUNC_WRITE: if (in_grid) life_grid[r][c] = v;
            FUNC_STEP:  evolve_grid();
            FUNC_READ:  if (in_grid) res.alive = life_grid[r][c];
            default:    ;
        endcase
        return res;
    endfunction

    // dense traffic in a patch straddling both wraps, the rest anywhere in the field range
    function automatic grid_op_t random_op();
        grid_op_t o;
        int       pick;
        pick    = $urandom_range(0, 99);
        o       = '0;
        o.v     = 1'($urandom_range(0, 1));
        o.r     = ROW_W'($urandom_range(0, 31));
        o.c     = COL_W'($urandom_range(0, 127));
        if (pick < 45)
        begin
            o.op = FUNC_WRITE;
            if (pick < 38)
            begin
                o.r = ROW_W'((ROWS - 3 + $urandom_range(0, 7)) % ROWS);
                o.c = COL_W'((COLS - 3 + $urandom_range(0, 7)) % COLS);
                o.v = ($urandom_range(0, 9) < 7);
            end
        end
        else if (pick < 55)
            o.op = FUNC_STEP;
        else if (pick < 95)
        begin
            o.op = FUNC_READ;
            if (pick < 85)
            begin
                o.r = ROW_W'((ROWS - 3 + $urandom_range(0, 7)) % ROWS);
                o.c = COL_W'((COLS - 3 + $urandom_range(0, 7)) % COLS);
            end
        end
        else
            o.op = FUNC_SPARE;
        return o;
    endfunction

    task automatic send_op(input grid_op_t o);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_valid      <= 1'b1;
        func           <= o.op;
        row            <= o.r;
        col            <= o.c;
        value          <= o.v;
        op_typed       <= o.typed;
        op_typed_alive <= o.alive;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || calm)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 9);
        end
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cell_result_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                want = predict_cell_result(func, row, col, value);
                if (op_typed)
                    want.alive = op_typed_alive;
                pending_cells.push_back(want);
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_cells.size() == 0)
                begin
                    $error("cell_alive: expected none, got %0b", cell_alive);
                    fail_count++;
                end
                else
                begin
                    want = pending_cells.pop_front();
                    if (cell_alive !== want.alive)
                    begin
                        $error("cell_alive: expected %0b, got %0b", want.alive, cell_alive);
                        fail_count++;
                    end
                    if (done_res !== want.done)
                    begin
                        $error("done_res: expected %0b, got %0b", want.done, done_res);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[life_toroidal_generation_step] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int k = 0; k < N_DIRECTED; k++)
            send_op(directed_ops[k]);
        for (int k = 0; k < N_RANDOM; k++)
        begin
            if (k == N_RANDOM - N_CALM)
                calm <= 1'b1;
            send_op(random_op());
        end
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending_cells.size() == 0)
            $display("[life_toroidal_generation_step] OK");
        else
            $display("[life_toroidal_generation_step] ERROR");
        $finish;
    end

endmodule
